// ===== design/rotated_image_source_lookup_defines.svh =====
// assertion macros used by the checker of the rotated image source lookup
// no dependencies; each macro samples on the rising edge of the clock given to it
`ifndef ROTATED_IMAGE_SOURCE_LOOKUP_DEFINES_SVH
`define ROTATED_IMAGE_SOURCE_LOOKUP_DEFINES_SVH

// same-cycle implication
`define RISL_ASSERT_NOW(label, clock, ante, cons, msg) \
  label: assert property (@(posedge clock) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define RISL_ASSERT_NEXT(label, clock, ante, cons, msg) \
  label: assert property (@(posedge clock) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== design/risl_pkg.sv =====
// shared types and fixed widths of the rotated image source lookup
// no dependencies; imported by every module of the block
package risl_pkg;

  localparam int COEF_W     = 16;
  localparam int POS_W      = 13;
  localparam int DIM_REG_W  = 13;
  localparam int COORD_W    = 12;
  localparam int IDX_W      = 24;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  // offset, product and sum widths of the rotation datapath
  localparam int OFF_W  = COORD_W + 2;
  localparam int PROD_W = OFF_W + COEF_W;
  localparam int SUM_W  = PROD_W + 1;

  // register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_COS_COEF     = 3'd0,
    REG_SIN_COEF     = 3'd1,
    REG_PIVOT_X      = 3'd2,
    REG_PIVOT_Y      = 3'd3,
    REG_IMAGE_LEFT   = 3'd4,
    REG_IMAGE_TOP    = 3'd5,
    REG_IMAGE_WIDTH  = 3'd6,
    REG_IMAGE_HEIGHT = 3'd7
  } risl_reg_t;

  // reset values
  localparam logic [COEF_W-1:0]    COS_RESET  = 16'd16384;
  localparam logic [COEF_W-1:0]    SIN_RESET  = 16'd0;
  localparam logic [POS_W-1:0]     POS_RESET  = 13'd0;
  localparam logic [DIM_REG_W-1:0] DIM_RESET  = 13'd1;

  typedef struct packed {
    logic signed [COEF_W-1:0] cos_coef;
    logic signed [COEF_W-1:0] sin_coef;
    logic signed [POS_W-1:0]  pivot_x;
    logic signed [POS_W-1:0]  pivot_y;
    logic signed [POS_W-1:0]  image_left;
    logic signed [POS_W-1:0]  image_top;
    logic [DIM_REG_W-1:0]     image_width;
    logic [DIM_REG_W-1:0]     image_height;
  } risl_cfg_t;

  typedef struct packed {
    logic [COORD_W-1:0] dest_x;
    logic [COORD_W-1:0] dest_y;
  } risl_in_t;

  typedef struct packed {
    logic [IDX_W-1:0] source_index;
    logic             hit;
  } risl_out_t;

endpackage

// ===== design/risl_cfg.sv =====
// configuration register file with image size clamping
// depends on risl_pkg
module risl_cfg #(
  parameter int MAX_DIM = 4096,
  localparam int DIM_W = $clog2(MAX_DIM + 1)
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_we,
  input  logic [risl_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [risl_pkg::CFG_DATA_W-1:0]     cfg_data,
  output risl_pkg::risl_cfg_t                 cfg,
  output logic [DIM_W-1:0]                    width_clamped,
  output logic [DIM_W-1:0]                    height_clamped
);
  import risl_pkg::*;

  localparam int unsigned MAXD = MAX_DIM;

  risl_cfg_t cfg_r;

  // register writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.cos_coef     <= COS_RESET;
      cfg_r.sin_coef     <= SIN_RESET;
      cfg_r.pivot_x      <= POS_RESET;
      cfg_r.pivot_y      <= POS_RESET;
      cfg_r.image_left   <= POS_RESET;
      cfg_r.image_top    <= POS_RESET;
      cfg_r.image_width  <= DIM_RESET;
      cfg_r.image_height <= DIM_RESET;
    end else if (cfg_we) begin
      case (risl_reg_t'(cfg_index))
        REG_COS_COEF:     cfg_r.cos_coef     <= cfg_data;
        REG_SIN_COEF:     cfg_r.sin_coef     <= cfg_data;
        REG_PIVOT_X:      cfg_r.pivot_x      <= cfg_data[POS_W-1:0];
        REG_PIVOT_Y:      cfg_r.pivot_y      <= cfg_data[POS_W-1:0];
        REG_IMAGE_LEFT:   cfg_r.image_left   <= cfg_data[POS_W-1:0];
        REG_IMAGE_TOP:    cfg_r.image_top    <= cfg_data[POS_W-1:0];
        REG_IMAGE_WIDTH:  cfg_r.image_width  <= cfg_data[DIM_REG_W-1:0];
        REG_IMAGE_HEIGHT: cfg_r.image_height <= cfg_data[DIM_REG_W-1:0];
        default: ;
      endcase
    end
  end

  assign cfg = cfg_r;

  // sizes saturate at the largest supported dimension
  assign width_clamped  = (32'(cfg_r.image_width) > MAXD) ?
                          DIM_W'(MAXD) : DIM_W'(cfg_r.image_width);
  assign height_clamped = (32'(cfg_r.image_height) > MAXD) ?
                          DIM_W'(MAXD) : DIM_W'(cfg_r.image_height);

endmodule

// ===== design/risl_rotate.sv =====
// pivot offset, coefficient products and rotation sums (three stages)
// depends on risl_pkg
module risl_rotate (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  risl_pkg::risl_in_t                    in_data,
  input  risl_pkg::risl_cfg_t                   cfg,
  output logic                                  sum_valid,
  input  logic                                  sum_ready,
  output logic signed [risl_pkg::SUM_W-1:0]     sum_x,
  output logic signed [risl_pkg::SUM_W-1:0]     sum_y
);
  import risl_pkg::*;

  logic s1_valid_r, s2_valid_r, s3_valid_r;
  logic s1_ready, s2_ready, s3_ready;

  logic signed [OFF_W-1:0]  dx_r, dy_r, dx_nxt, dy_nxt;
  logic signed [PROD_W-1:0] p_xc_r, p_ys_r, p_yc_r, p_xs_r;
  logic signed [PROD_W-1:0] p_xc_nxt, p_ys_nxt, p_yc_nxt, p_xs_nxt;
  logic signed [SUM_W-1:0]  sx_r, sy_r, sx_nxt, sy_nxt;

  // a stage takes a new item when empty or when its item moves on
  assign s3_ready = !s3_valid_r || sum_ready;
  assign s2_ready = !s2_valid_r || s3_ready;
  assign s1_ready = !s1_valid_r || s2_ready;
  assign in_ready = s1_ready;

  // stage 1: offset from the pivot
  assign dx_nxt = $signed({2'b00, in_data.dest_x}) - OFF_W'($signed(cfg.pivot_x));
  assign dy_nxt = $signed({2'b00, in_data.dest_y}) - OFF_W'($signed(cfg.pivot_y));

  // stage 2: four coefficient products
  assign p_xc_nxt = dx_r * $signed(cfg.cos_coef);
  assign p_ys_nxt = dy_r * $signed(cfg.sin_coef);
  assign p_yc_nxt = dy_r * $signed(cfg.cos_coef);
  assign p_xs_nxt = dx_r * $signed(cfg.sin_coef);

  // stage 3: rotation sums
  assign sx_nxt = SUM_W'(p_xc_r) + SUM_W'(p_ys_r);
  assign sy_nxt = SUM_W'(p_yc_r) - SUM_W'(p_xs_r);

  // valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      s2_valid_r <= 1'b0;
      s3_valid_r <= 1'b0;
    end else begin
      if (s1_ready) s1_valid_r <= in_valid;
      if (s2_ready) s2_valid_r <= s1_valid_r;
      if (s3_ready) s3_valid_r <= s2_valid_r;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_valid && s1_ready) begin
      dx_r <= dx_nxt;
      dy_r <= dy_nxt;
    end
    if (s1_valid_r && s2_ready) begin
      p_xc_r <= p_xc_nxt;
      p_ys_r <= p_ys_nxt;
      p_yc_r <= p_yc_nxt;
      p_xs_r <= p_xs_nxt;
    end
    if (s2_valid_r && s3_ready) begin
      sx_r <= sx_nxt;
      sy_r <= sy_nxt;
    end
  end

  assign sum_valid = s3_valid_r;
  assign sum_x     = sx_r;
  assign sum_y     = sy_r;

endmodule

// ===== design/risl_place.sv =====
// truncating scale, image bounds test and row-major index (three stages)
// depends on risl_pkg
module risl_place #(
  parameter int MAX_DIM        = 4096,
  parameter int COEF_FRAC_BITS = 14,
  localparam int DIM_W = $clog2(MAX_DIM + 1)
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  sum_valid,
  output logic                                  sum_ready,
  input  logic signed [risl_pkg::SUM_W-1:0]     sum_x,
  input  logic signed [risl_pkg::SUM_W-1:0]     sum_y,
  input  risl_pkg::risl_cfg_t                   cfg,
  input  logic [DIM_W-1:0]                      width_clamped,
  input  logic [DIM_W-1:0]                      height_clamped,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output risl_pkg::risl_out_t                   out_data
);
  import risl_pkg::*;

  localparam int Q_W   = SUM_W - COEF_FRAC_BITS;
  localparam int S_W   = ((Q_W > POS_W) ? Q_W : POS_W) + 1;
  localparam int OX_W  = S_W + 1;
  localparam int CMP_W = ((OX_W - 1) > DIM_W) ? (OX_W - 1) : DIM_W;
  localparam int P_W   = 2 * DIM_W;
  localparam int IW    = ((P_W + 1) > IDX_W) ? (P_W + 1) : IDX_W;
  localparam logic [SUM_W-1:0] BIAS = SUM_W'((64'd1 << COEF_FRAC_BITS) - 64'd1);

  logic s4_valid_r, s5_valid_r, s6_valid_r;
  logic s4_ready, s5_ready, s6_ready;

  logic signed [SUM_W-1:0] tx, ty, shx, shy;
  logic signed [Q_W-1:0]   qx, qy;
  logic signed [POS_W:0]   off_x, off_y;
  logic signed [OX_W-1:0]  ox_r, oy_r, ox_nxt, oy_nxt;
  logic                    hit_r, hit_nxt;
  logic [P_W-1:0]          prod_r, prod_nxt;
  logic [DIM_W-1:0]        oxl_r;
  logic [IW-1:0]           idx_sum;
  risl_out_t               out_r, out_nxt;

  assign s6_ready  = !s6_valid_r || out_ready;
  assign s5_ready  = !s5_valid_r || s6_ready;
  assign s4_ready  = !s4_valid_r || s5_ready;
  assign sum_ready = s4_ready;

  // stage 4: divide by the coefficient scale toward zero, then move into image space
  assign tx  = sum_x + (sum_x[SUM_W-1] ? $signed(BIAS) : $signed(SUM_W'(0)));
  assign ty  = sum_y + (sum_y[SUM_W-1] ? $signed(BIAS) : $signed(SUM_W'(0)));
  assign shx = tx >>> COEF_FRAC_BITS;
  assign shy = ty >>> COEF_FRAC_BITS;
  assign qx  = shx[Q_W-1:0];
  assign qy  = shy[Q_W-1:0];
  // pivot minus image corner folds both additions into one
  assign off_x  = (POS_W+1)'($signed(cfg.pivot_x)) - (POS_W+1)'($signed(cfg.image_left));
  assign off_y  = (POS_W+1)'($signed(cfg.pivot_y)) - (POS_W+1)'($signed(cfg.image_top));
  assign ox_nxt = OX_W'(qx) + OX_W'(off_x);
  assign oy_nxt = OX_W'(qy) + OX_W'(off_y);

  // stage 5: bounds test and row offset product
  assign hit_nxt = !ox_r[OX_W-1] && !oy_r[OX_W-1] &&
                   (CMP_W'(ox_r[OX_W-2:0]) < CMP_W'(width_clamped)) &&
                   (CMP_W'(oy_r[OX_W-2:0]) < CMP_W'(height_clamped));
  assign prod_nxt = oy_r[DIM_W-1:0] * width_clamped;

  // stage 6: index, zero on a miss
  assign idx_sum              = IW'(prod_r) + IW'(oxl_r);
  assign out_nxt.hit          = hit_r;
  assign out_nxt.source_index = hit_r ? idx_sum[IDX_W-1:0] : '0;

  // valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s4_valid_r <= 1'b0;
      s5_valid_r <= 1'b0;
      s6_valid_r <= 1'b0;
    end else begin
      if (s4_ready) s4_valid_r <= sum_valid;
      if (s5_ready) s5_valid_r <= s4_valid_r;
      if (s6_ready) s6_valid_r <= s5_valid_r;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (sum_valid && s4_ready) begin
      ox_r <= ox_nxt;
      oy_r <= oy_nxt;
    end
    if (s4_valid_r && s5_ready) begin
      hit_r  <= hit_nxt;
      prod_r <= prod_nxt;
      oxl_r  <= ox_r[DIM_W-1:0];
    end
    if (s5_valid_r && s6_ready) begin
      out_r <= out_nxt;
    end
  end

  assign out_valid = s6_valid_r;
  assign out_data  = out_r;

endmodule

// ===== design/rotated_image_source_lookup.sv =====
// Rotated image source lookup. Takes one destination pixel (dest_x, dest_y) per
// clock while in_ready is high and returns the row-major index of the image pixel
// that rotates onto it, with hit high when that source point lies inside the
// placed image (index is zero on a miss). It is a six-stage pipeline: pivot
// offset, four coefficient products, rotation sums, truncating scale with the
// shift to image space, bounds test with the row multiply, and the index add.
// Throughput is one transfer per clock unless stalled; the product stage holds one
// 14x16 multiplier per term. Each stage stalls on its own, so a held output only
// stops the items behind it as they catch up. The user must see that configuration
// is written through cfg_we/cfg_index/cfg_data only while no item is in flight; the block does not enforce it.
// depends on risl_pkg, risl_cfg, risl_rotate, risl_place
module rotated_image_source_lookup #(
  parameter int MAX_DIM        = 4096,
  parameter int COEF_FRAC_BITS = 14
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  risl_pkg::risl_in_t               in_data,
  output logic                             out_valid,
  input  logic                             out_ready,
  output risl_pkg::risl_out_t              out_data,
  input  logic                             cfg_we,
  input  logic [risl_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [risl_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import risl_pkg::*;

  localparam int DIM_W = $clog2(MAX_DIM + 1);

  risl_cfg_t               cfg;
  logic [DIM_W-1:0]        width_clamped, height_clamped;
  logic                    sum_valid, sum_ready;
  logic signed [SUM_W-1:0] sum_x, sum_y;

  // configuration registers
  risl_cfg #(.MAX_DIM(MAX_DIM)) u_cfg (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .cfg            (cfg),
    .width_clamped  (width_clamped),
    .height_clamped (height_clamped)
  );

  // front half: rotation
  risl_rotate u_rotate (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .cfg       (cfg),
    .sum_valid (sum_valid),
    .sum_ready (sum_ready),
    .sum_x     (sum_x),
    .sum_y     (sum_y)
  );

  // back half: placement and index
  risl_place #(
    .MAX_DIM        (MAX_DIM),
    .COEF_FRAC_BITS (COEF_FRAC_BITS)
  ) u_place (
    .clk            (clk),
    .rst_n          (rst_n),
    .sum_valid      (sum_valid),
    .sum_ready      (sum_ready),
    .sum_x          (sum_x),
    .sum_y          (sum_y),
    .cfg            (cfg),
    .width_clamped  (width_clamped),
    .height_clamped (height_clamped),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_data       (out_data)
  );

endmodule

// ===== design/risl_checker.sv =====
// port-level assertions for the rotated image source lookup, bound to the top level
// depends on risl_pkg and rotated_image_source_lookup_defines.svh
`include "rotated_image_source_lookup_defines.svh"

module risl_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                out_valid,
  input logic                out_ready,
  input risl_pkg::risl_out_t out_data
);
  import risl_pkg::*;

  // reset empties the pipeline
  `RISL_ASSERT_NEXT(a_reset_empty, clk, !rst_n, !out_valid, "output valid after reset")

  // a miss carries a zero index
  `RISL_ASSERT_NOW(a_miss_zero, clk, rst_n && out_valid && !out_data.hit, out_data.source_index == '0, "nonzero index on a miss")

  // a stalled result stays put
  `RISL_ASSERT_NEXT(a_stall_hold, clk, rst_n && out_valid && !out_ready, out_valid && $stable(out_data), "stalled result changed")

endmodule

bind rotated_image_source_lookup risl_checker u_risl_checker (.*);
